// ===== rtl/vadi_pkg.sv =====
// Shared types and constants for the vertex attribute dedup indexer.
`timescale 1ns / 1ps
`default_nettype none

package vadi_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int NUM_COMP        = 8;
    localparam int TOL_W           = 31;
    localparam int OUT_IDX_W       = 10;
    localparam int OUTCOME_W       = 2;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_REUSE  = 2'd0,
        OUTCOME_APPEND = 2'd1,
        OUTCOME_FULL   = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Control part of a probe token moving down the cell chain.
    typedef struct packed {
        logic valid;
        logic match;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/vadi_cell.sv =====
// One chain cell: holds one vertex component store and checks one component per probe.
`timescale 1ns / 1ps
`default_nettype none

module vadi_cell #(
    parameter int STORE_DEPTH = vadi_pkg::DEF_STORE_DEPTH,
    parameter int COORD_WIDTH = vadi_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [COORD_WIDTH-1:0]        i_comp,
    input  wire logic [vadi_pkg::TOL_W-1:0]    i_tol,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] i_wr_addr,
    input  wire vadi_pkg::t_tok                i_tok,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] i_idx,
    output vadi_pkg::t_tok                     o_tok,
    output logic [$clog2(STORE_DEPTH)-1:0]     o_idx
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CMP_W = (COORD_WIDTH > vadi_pkg::TOL_W) ? COORD_WIDTH : vadi_pkg::TOL_W;
    localparam logic [COORD_WIDTH-1:0] SIGN_BIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [COORD_WIDTH-1:0] r_comp;
    logic [COORD_WIDTH-1:0] r_rdata;
    logic [COORD_WIDTH-1:0] mem [STORE_DEPTH];
    vadi_pkg::t_tok         r_tok;
    logic [IDX_W-1:0]       r_idx;
    logic [COORD_WIDTH-1:0] w_diff;
    logic                   w_near;

    // Incoming component kept offset-binary so plain unsigned compare orders it.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_comp <= i_comp ^ SIGN_BIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= r_comp;
        end
        r_rdata <= mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= i_idx;
    end

    assign w_diff = (r_comp >= r_rdata) ? (r_comp - r_rdata) : (r_rdata - r_comp);
    assign w_near = CMP_W'(w_diff) < CMP_W'(i_tol);

    assign o_tok.valid = r_tok.valid;
    assign o_tok.match = r_tok.match & w_near;
    assign o_idx       = r_idx;

endmodule

`default_nettype wire

// ===== rtl/vertex_attribute_dedup_indexer_unit.sv =====
// Top level of the vertex attribute dedup indexer: control, config and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  -----------------------------------------
// in        request    i_in_valid / o_in_stall   i_pos_*, i_tex_*, i_norm_*, i_first_of_mesh
// out       result     o_out_valid / i_out_stall o_vertex_index, o_outcome
// cfg       write      i_cfg_valid / o_cfg_ready i_cfg_data (match tolerance)
//
// A request of a store holding N valid entries issues one probe per cycle into the chain
// of eight component cells (one read port per cell memory), and the last probe passes
// through the registers of all eight cells before it leaves. Probes left in the chain
// after an early match drain before the next request is taken.
// Reset clears the entry count, the control state and sets the tolerance to 655. The
// stores are not cleared; only entries below the count are ever probed.
// A result waits in the output register while i_out_stall is high; the next request
// is still taken and searched, and holds in the done state until the register frees.

module vertex_attribute_dedup_indexer_unit #(
    parameter int STORE_DEPTH = vadi_pkg::DEF_STORE_DEPTH,
    parameter int COORD_WIDTH = vadi_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  wire logic signed [COORD_WIDTH-1:0]      i_tex_u,
    input  wire logic signed [COORD_WIDTH-1:0]      i_tex_v,
    input  wire logic signed [COORD_WIDTH-1:0]      i_norm_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_norm_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_norm_z,
    input  wire logic                               i_first_of_mesh,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [vadi_pkg::OUT_IDX_W-1:0]          o_vertex_index,
    output logic [vadi_pkg::OUTCOME_W-1:0]          o_outcome,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [vadi_pkg::TOL_W-1:0]         i_cfg_data
);

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int NCOMP  = vadi_pkg::NUM_COMP;
    localparam int INFL_W = $clog2(NCOMP + 1);
    localparam int OIW    = vadi_pkg::OUT_IDX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_DEPTH);

    vadi_pkg::t_state r_state, n_state;

    logic [vadi_pkg::TOL_W-1:0] r_tol;
    logic [CNT_W-1:0]           r_count;    // valid entries in the stores
    logic [CNT_W-1:0]           r_issue;    // next entry to probe
    logic [INFL_W-1:0]          r_inflight; // probes inside the chain
    logic [OIW-1:0]             r_res_idx;
    vadi_pkg::t_outcome         r_res_outcome;
    logic                       r_o_valid;
    logic [OIW-1:0]             r_o_idx;
    vadi_pkg::t_outcome         r_o_outcome;

    // strobes from the output decode
    logic w_accept;
    logic w_load;
    logic w_issue;
    logic w_decide;
    logic w_wr_en;
    logic w_out_load;

    logic w_out_free;
    logic w_hit;
    logic w_miss;
    logic w_end_last;
    logic [OIW+IDX_W-1:0] w_hit_wide;
    logic [OIW+CNT_W-1:0] w_app_wide;

    logic [COORD_WIDTH-1:0] w_comp [NCOMP];
    vadi_pkg::t_tok         w_tok  [NCOMP+1];
    logic [IDX_W-1:0]       w_idx  [NCOMP+1];

    assign w_comp[0] = i_pos_x;
    assign w_comp[1] = i_pos_y;
    assign w_comp[2] = i_pos_z;
    assign w_comp[3] = i_tex_u;
    assign w_comp[4] = i_tex_v;
    assign w_comp[5] = i_norm_x;
    assign w_comp[6] = i_norm_y;
    assign w_comp[7] = i_norm_z;

    // ---------------------------------------------------------------
    // Probe chain: each cell compares one component and passes the
    // running match flag on; probes leave the chain in index order.
    // ---------------------------------------------------------------
    assign w_tok[0].valid = w_issue;
    assign w_tok[0].match = 1'b1;
    assign w_idx[0]       = r_issue[IDX_W-1:0];

    for (genvar g = 0; g < NCOMP; g++) begin : g_cell
        vadi_cell #(
            .STORE_DEPTH (STORE_DEPTH),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_load),
            .i_comp    (w_comp[g]),
            .i_tol     (r_tol),
            .i_wr_en   (w_wr_en),
            .i_wr_addr (r_count[IDX_W-1:0]),
            .i_tok     (w_tok[g]),
            .i_idx     (w_idx[g]),
            .o_tok     (w_tok[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Search decision. The chain is empty when a request is taken, so
    // every probe leaving it belongs to the current request.
    // ---------------------------------------------------------------
    assign w_end_last = w_tok[NCOMP].valid && (CNT_W'(w_idx[NCOMP]) == (r_count - 1'b1));
    assign w_hit      = w_tok[NCOMP].valid && w_tok[NCOMP].match;
    assign w_miss     = !w_hit && ((r_count == '0) || w_end_last);

    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // low bits of the index go out; zero-extend when the store is small
    assign w_hit_wide = {{OIW{1'b0}}, w_idx[NCOMP]};
    assign w_app_wide = {{OIW{1'b0}}, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vadi_pkg::ST_IDLE: begin
                if (i_in_valid && r_inflight == '0) begin
                    n_state = vadi_pkg::ST_SCAN;
                end
            end
            vadi_pkg::ST_SCAN: begin
                if (w_hit || w_miss) begin
                    n_state = vadi_pkg::ST_DONE;
                end
            end
            vadi_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = vadi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vadi_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load     = 1'b0;
        w_issue    = 1'b0;
        w_decide   = 1'b0;
        w_wr_en    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            vadi_pkg::ST_IDLE: begin
                o_in_stall = (r_inflight != '0);
                w_load     = i_in_valid && (r_inflight == '0);
            end
            vadi_pkg::ST_SCAN: begin
                w_issue  = (r_issue < r_count);
                w_decide = w_hit || w_miss;
                w_wr_en  = w_miss && (r_count != FULL_COUNT);
            end
            vadi_pkg::ST_DONE: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vadi_pkg::ST_IDLE;
            r_tol      <= vadi_pkg::TOL_RESET;
            r_count    <= '0;
            r_issue    <= '0;
            r_inflight <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end

            // first of a mesh empties the store before the search
            if (w_accept && i_first_of_mesh) begin
                r_count <= '0;
            end else if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end

            if (w_accept) begin
                r_issue <= '0;
            end else if (w_issue) begin
                r_issue <= r_issue + 1'b1;
            end

            r_inflight <= r_inflight + INFL_W'(w_issue) - INFL_W'(w_tok[NCOMP].valid);

            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_decide) begin
            if (w_hit) begin
                r_res_idx     <= w_hit_wide[OIW-1:0];
                r_res_outcome <= vadi_pkg::OUTCOME_REUSE;
            end else if (r_count == FULL_COUNT) begin
                r_res_idx     <= '0;
                r_res_outcome <= vadi_pkg::OUTCOME_FULL;
            end else begin
                r_res_idx     <= w_app_wide[OIW-1:0];
                r_res_outcome <= vadi_pkg::OUTCOME_APPEND;
            end
        end
        if (w_out_load) begin
            r_o_idx     <= r_res_idx;
            r_o_outcome <= r_res_outcome;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_o_valid;
    assign o_vertex_index = r_o_idx;
    assign o_outcome      = r_o_outcome;

endmodule

`default_nettype wire

// ===== tb/sv/vadi_index_monitor.sv =====
// Scoreboard for the vertex dedup indexer: predicts each vertex index and checks the results.
`timescale 1ns / 1ps

module vadi_index_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic [31:0]                    i_pos_x,
    input  wire logic [31:0]                    i_pos_y,
    input  wire logic [31:0]                    i_pos_z,
    input  wire logic [31:0]                    i_tex_u,
    input  wire logic [31:0]                    i_tex_v,
    input  wire logic [31:0]                    i_norm_x,
    input  wire logic [31:0]                    i_norm_y,
    input  wire logic [31:0]                    i_norm_z,
    input  wire logic                           i_first_of_mesh,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [vadi_pkg::OUT_IDX_W-1:0] i_vertex_index,
    input  wire logic [vadi_pkg::OUTCOME_W-1:0] i_outcome,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [vadi_pkg::TOL_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import vadi_pkg::*;

    localparam int          DEPTH    = DEF_STORE_DEPTH;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    typedef logic [NUM_COMP-1:0][31:0] attr_vec_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        t_outcome             outcome;
    } idx_result_t;

    // Keys are kept offset-binary so that an unsigned distance is exact.
    attr_vec_t        unique_verts [DEPTH];
    int               unique_count;
    logic [TOL_W-1:0] tolerance;
    idx_result_t      expected_idx_q [$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic idx_result_t index_vertex(attr_vec_t raw, logic fresh);
        attr_vec_t   key;
        logic [31:0] diff;
        logic        near;
        idx_result_t r;
        for (int c = 0; c < NUM_COMP; c++)
            key[c] = raw[c] ^ SIGN_BIT;
        if (fresh)
            unique_count = 0;
        for (int i = 0; i < unique_count; i++) begin
            near = 1'b1;
            for (int c = 0; c < NUM_COMP; c++) begin
                diff = (key[c] >= unique_verts[i][c]) ? key[c] - unique_verts[i][c]
                                                     : unique_verts[i][c] - key[c];
                if (diff >= {1'b0, tolerance})
                    near = 1'b0;
            end
            if (near) begin
                r.index   = i[OUT_IDX_W-1:0];
                r.outcome = OUTCOME_REUSE;
                return r;
            end
        end
        if (unique_count >= DEPTH) begin
            r.index   = '0;
            r.outcome = OUTCOME_FULL;
            return r;
        end
        unique_verts[unique_count] = key;
        r.index   = unique_count[OUT_IDX_W-1:0];
        r.outcome = OUTCOME_APPEND;
        unique_count++;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        idx_result_t want;
        if (!i_rst_n) begin
            unique_count = 0;
            tolerance    = TOL_RESET;
            expected_idx_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                tolerance = i_cfg_data;
            // a result always leaves after its request is taken, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                if (expected_idx_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result index %0d outcome %0d with no request pending",
                                 $time, i_vertex_index, i_outcome);
                end else begin
                    want = expected_idx_q.pop_front();
                    if (i_vertex_index !== want.index || i_outcome !== want.outcome) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: got index %0d outcome %0d, expected index %0d outcome %0d",
                                     $time, i_vertex_index, i_outcome, want.index, want.outcome);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = index_vertex({i_norm_z, i_norm_y, i_norm_x, i_tex_v,
                                     i_tex_u, i_pos_z, i_pos_y, i_pos_x},
                                    i_first_of_mesh);
                expected_idx_q = {expected_idx_q, want};
            end
        end
        o_pending <= expected_idx_q.size();
    end

endmodule

// ===== tb/sv/vertex_attribute_dedup_indexer_unit_tb.sv =====
// Testbench top for the vertex dedup indexer: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module vertex_attribute_dedup_indexer_unit_tb;
    import vadi_pkg::*;

    localparam int               CYCLE_LIMIT = 4_000_000;
    localparam int               MESH_ITEMS  = 340;
    localparam int               FILL_ITEMS  = 200;
    localparam logic [31:0]      Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0]      Q_MIN       = 32'h8000_0000;
    localparam logic [TOL_W-1:0] TOL_MAX     = '1;

    // component order: pos x/y/z, tex u/v, normal x/y/z
    typedef logic [NUM_COMP-1:0][31:0] attr_vec_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    attr_vec_t            attr;
    logic                 first_of_mesh;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic [OUTCOME_W-1:0] outcome;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TOL_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int unsigned          cycle_count = 0;

    // traffic shaping shared between the request and result sides
    bit                   tx_quiet;
    bit                   rx_quiet;
    int                   rx_hold_cycles = 0;
    int                   random_sent;
    logic [TOL_W-1:0]     tol_now;

    always #2 clk = ~clk;

    vertex_attribute_dedup_indexer_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pos_x        (attr[0]),
        .i_pos_y        (attr[1]),
        .i_pos_z        (attr[2]),
        .i_tex_u        (attr[3]),
        .i_tex_v        (attr[4]),
        .i_norm_x       (attr[5]),
        .i_norm_y       (attr[6]),
        .i_norm_z       (attr[7]),
        .i_first_of_mesh(first_of_mesh),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_vertex_index (vertex_index),
        .o_outcome      (outcome),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    vadi_index_monitor u_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_pos_x        (attr[0]),
        .i_pos_y        (attr[1]),
        .i_pos_z        (attr[2]),
        .i_tex_u        (attr[3]),
        .i_tex_v        (attr[4]),
        .i_norm_x       (attr[5]),
        .i_norm_y       (attr[6]),
        .i_norm_z       (attr[7]),
        .i_first_of_mesh(first_of_mesh),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_vertex_index (vertex_index),
        .i_outcome      (outcome),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL vertex_attribute_dedup_indexer_unit");
            $finish;
        end
    end

    function automatic attr_vec_t splat(logic [31:0] c);
        return {NUM_COMP{c}};
    endfunction

    function automatic attr_vec_t random_vec();
        attr_vec_t v;
        for (int c = 0; c < NUM_COMP; c++)
            v[c] = $urandom;
        return v;
    endfunction

    // Nudge every component by up to the tolerance plus one (at most 4097) either way,
    // so that some land just inside and some just outside the closeness limit.
    function automatic attr_vec_t jitter(attr_vec_t base, logic [TOL_W-1:0] tol);
        attr_vec_t   v;
        int unsigned span;
        span = (tol > 4096) ? 4096 : tol;
        for (int c = 0; c < NUM_COMP; c++)
            v[c] = base[c] + $urandom_range(0, 2 * span + 2) - (span + 1);
        return v;
    endfunction

    // One request: optional idle gap, then hold the payload until it is taken.
    // Always returns at the accepting edge with valid still high.
    task automatic send_vertex(input attr_vec_t v, input logic fresh);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        attr          <= v;
        first_of_mesh <= fresh;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering requests until every predicted index has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Tolerance is only changed with the block idle.
    task automatic write_tolerance(input logic [TOL_W-1:0] t);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_now = t;
    endtask

    // A mesh: mostly repeats and near-repeats of a few base vertices, some
    // unrelated noise, and now and then a stray first-of-mesh flag mid-stream.
    task automatic send_mesh(input int len);
        attr_vec_t pool [8];
        attr_vec_t v;
        int        pool_n;
        int        pick;
        pool_n = $urandom_range(1, 8);
        for (int p = 0; p < 8; p++)
            pool[p] = random_vec();
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                v = random_vec();
            else if (pick < 35)
                v = pool[$urandom_range(0, pool_n - 1)];
            else
                v = jitter(pool[$urandom_range(0, pool_n - 1)], tol_now);
            send_vertex(v, k == 0 || $urandom_range(0, 49) == 0);
            random_sent++;
        end
    endtask

    // Result side: a random stall before each result, or a long hold-off when the
    // request side asks for one.
    initial begin : result_sink
        int wait_cycles;
        out_stall = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            wait_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
            if (rx_hold_cycles > 0) begin
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        attr_vec_t v;
        attr_vec_t last_fill;
        bit        hold_done;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        first_of_mesh = 1'b0;
        attr          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_done     = 1'b0;
        random_sent   = 0;
        tol_now       = TOL_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, default tolerance of 655.
        v = '0;
        send_vertex(v, 1'b1);               // empty store: new entry
        send_vertex(v, 1'b0);               // exact repeat
        v[0] = 32'd654;
        send_vertex(v, 1'b0);               // one step inside the limit
        v[0] = 32'd655;
        send_vertex(v, 1'b0);               // on the limit is not close
        v[0] = -32'sd654;
        send_vertex(v, 1'b0);               // inside from the negative side
        v = '0;
        v[7] = -32'sd655;
        send_vertex(v, 1'b0);
        send_vertex(splat(Q_MAX), 1'b0);
        send_vertex(splat(Q_MIN), 1'b0);
        send_vertex({4{Q_MAX, Q_MIN}}, 1'b0);
        send_vertex(splat(Q_MAX - 32'd600), 1'b0);
        send_vertex(splat(Q_MIN + 32'd654), 1'b0);
        send_vertex(splat('0), 1'b1);       // new mesh forgets the old entries

        // zero tolerance: even an exact copy is appended
        write_tolerance('0);
        send_vertex(splat('0), 1'b0);
        send_vertex(splat('0), 1'b0);

        // widest tolerance: distance of exactly the limit still fails,
        // and the first close entry wins over later ones
        write_tolerance(TOL_MAX);
        send_vertex(splat('0), 1'b1);
        send_vertex(splat(Q_MAX), 1'b0);
        send_vertex(splat(Q_MIN), 1'b0);
        send_vertex(splat(32'h3FFF_FFFF), 1'b0);

        write_tolerance(31'd1);
        send_vertex(splat('0), 1'b1);
        send_vertex(splat('0), 1'b0);
        v = '0;
        v[3] = 32'd1;
        send_vertex(v, 1'b0);

        // Grow a long store so that searches run deep.
        write_tolerance('0);
        for (int n = 0; n < FILL_ITEMS; n++) begin
            last_fill = random_vec();
            send_vertex(last_fill, n == 0);
        end
        send_vertex(random_vec(), 1'b0);
        send_vertex(random_vec(), 1'b0);
        write_tolerance(31'd1);
        send_vertex(last_fill, 1'b0);       // reuse of a deep entry
        send_vertex(random_vec(), 1'b0);    // appended after the deep search
        send_vertex(random_vec(), 1'b1);    // new mesh starts at index 0

        // Random meshes under a spread of tolerances.
        while (random_sent < MESH_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       write_tolerance('0);
                1:       write_tolerance(31'd1);
                2:       write_tolerance(TOL_RESET);
                3:       write_tolerance(TOL_W'($urandom_range(2, 65536)));
                4:       write_tolerance(TOL_W'($urandom));
                default: write_tolerance(TOL_MAX);
            endcase
            repeat ($urandom_range(2, 5)) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
                if (!hold_done && random_sent >= 100) begin
                    // back-pressure: results held off while requests keep coming
                    hold_done      = 1'b1;
                    tx_quiet       = 1'b1;
                    rx_hold_cycles = 300;
                    send_mesh(40);
                end else begin
                    send_mesh($urandom_range(1, 40));
                end
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS vertex_attribute_dedup_indexer_unit");
        else
            $display("FAIL vertex_attribute_dedup_indexer_unit");
        $finish;
    end

endmodule
